// File: rtl/midpoint_line_clipper_unit_assert.svh
`ifndef MIDPOINT_LINE_CLIPPER_UNIT_ASSERT_SVH
`define MIDPOINT_LINE_CLIPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define MLC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mlc_pkg.sv
package mlc_pkg;

   localparam int MAX_RESULTS = 64;
   localparam int RES_BITS    = $clog2(MAX_RESULTS + 1);
   localparam int CODE_BITS   = 4;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CODE_BITS-1:0] CODE_LEFT   = 4'd8;
   localparam logic [CODE_BITS-1:0] CODE_RIGHT  = 4'd4;
   localparam logic [CODE_BITS-1:0] CODE_BOTTOM = 4'd2;
   localparam logic [CODE_BITS-1:0] CODE_TOP    = 4'd1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_X_MIN = 2'd0,
      REG_Y_MIN = 2'd1,
      REG_X_MAX = 2'd2,
      REG_Y_MAX = 2'd3
   } csr_index_type;

   // engine to output stage: a visible piece, or the end of a segment
   typedef struct packed {
      logic valid;
      logic done;
   } mlc_evt_type;

endpackage

// File: rtl/mlc_front.sv
module mlc_front
   import mlc_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         seg_valid,
   input  logic                         seg_ready,
   output logic signed [COORD_BITS-1:0] seg_ax,
   output logic signed [COORD_BITS-1:0] seg_ay,
   output logic signed [COORD_BITS-1:0] seg_bx,
   output logic signed [COORD_BITS-1:0] seg_by
);

   localparam int SEG_BITS = 4 * COORD_BITS;

   logic [SEG_BITS-1:0] queue_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                push, pop;

   assign req_ready = (count_ff != 2'd2);
   assign seg_valid = (count_ff != 2'd0);
   assign push      = req_valid && req_ready;
   assign pop       = seg_valid && seg_ready;

   assign {seg_ax, seg_ay, seg_bx, seg_by} = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= {req_start_x, req_start_y, req_end_x, req_end_y};
      end
   end

endmodule

// File: rtl/mlc_engine.sv
module mlc_engine
   import mlc_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int STACK_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] window_x_min,
   input  logic signed [COORD_BITS-1:0] window_y_min,
   input  logic signed [COORD_BITS-1:0] window_x_max,
   input  logic signed [COORD_BITS-1:0] window_y_max,
   input  logic                         seg_valid,
   output logic                         seg_ready,
   input  logic signed [COORD_BITS-1:0] seg_ax,
   input  logic signed [COORD_BITS-1:0] seg_ay,
   input  logic signed [COORD_BITS-1:0] seg_bx,
   input  logic signed [COORD_BITS-1:0] seg_by,
   output mlc_evt_type                  evt,
   input  logic                         evt_ready,
   output logic signed [COORD_BITS-1:0] piece_x1,
   output logic signed [COORD_BITS-1:0] piece_y1,
   output logic signed [COORD_BITS-1:0] piece_x2,
   output logic signed [COORD_BITS-1:0] piece_y2
);

   localparam int SEG_BITS  = 4 * COORD_BITS;
   localparam int LVL_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(STACK_DEPTH);
   localparam logic [LVL_BITS-1:0] LVL_SPLIT_MAX = LVL_BITS'(STACK_DEPTH - 2);
   localparam logic [RES_BITS-1:0] RES_LIMIT     = RES_BITS'(MAX_RESULTS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_READ,
      S_LOAD,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [COORD_BITS-1:0] ax_in, ay_in, bx_in, by_in;
   logic [LVL_BITS-1:0]          level_ff, level_in;
   logic [RES_BITS-1:0]          count_ff, count_in;

   logic [SEG_BITS-1:0]          stack_mem [STACK_DEPTH];
   logic [SEG_BITS-1:0]          rd_data_ff;

   logic [CODE_BITS-1:0]         code_a, code_b;
   logic signed [COORD_BITS:0]   diff_x, diff_y, sum_x, sum_y, adj_x, adj_y;
   logic signed [COORD_BITS-1:0] mid_x, mid_y;
   logic                         is_inside, is_reject, is_short, is_full, do_split;
   logic                         push;
   logic [RES_BITS-1:0]          count_next;

   function automatic logic [CODE_BITS-1:0] outcode(
      input logic signed [COORD_BITS-1:0] x,
      input logic signed [COORD_BITS-1:0] y
   );
      logic [CODE_BITS-1:0] c;
      c = '0;
      if (x < window_x_min) c = c | CODE_LEFT;
      if (x > window_x_max) c = c | CODE_RIGHT;
      if (y < window_y_min) c = c | CODE_BOTTOM;
      if (y > window_y_max) c = c | CODE_TOP;
      return c;
   endfunction

   always_comb begin
      code_a    = outcode(ax_ff, ay_ff);
      code_b    = outcode(bx_ff, by_ff);
      diff_x    = {ax_ff[COORD_BITS-1], ax_ff} - {bx_ff[COORD_BITS-1], bx_ff};
      diff_y    = {ay_ff[COORD_BITS-1], ay_ff} - {by_ff[COORD_BITS-1], by_ff};
      sum_x     = {ax_ff[COORD_BITS-1], ax_ff} + {bx_ff[COORD_BITS-1], bx_ff};
      sum_y     = {ay_ff[COORD_BITS-1], ay_ff} + {by_ff[COORD_BITS-1], by_ff};
      // round toward zero: bump odd negative sums before the shift
      adj_x     = sum_x + (COORD_BITS+1)'(sum_x[COORD_BITS] & sum_x[0]);
      adj_y     = sum_y + (COORD_BITS+1)'(sum_y[COORD_BITS] & sum_y[0]);
      mid_x     = adj_x[COORD_BITS:1];
      mid_y     = adj_y[COORD_BITS:1];
      is_inside = (code_a == '0) && (code_b == '0);
      is_reject = ((code_a & code_b) != '0);
      is_short  = (diff_x >= -(COORD_BITS+1)'(1)) && (diff_x <= (COORD_BITS+1)'(1)) &&
                  (diff_y >= -(COORD_BITS+1)'(1)) && (diff_y <= (COORD_BITS+1)'(1));
      is_full   = (level_ff > LVL_SPLIT_MAX);
      do_split  = !is_inside && !is_reject && !is_short && !is_full;
      count_next = count_ff + RES_BITS'(1);
   end

   assign seg_ready = (state_ff == S_IDLE);
   assign piece_x1  = ax_ff;
   assign piece_y1  = ay_ff;
   assign piece_x2  = bx_ff;
   assign piece_y2  = by_ff;
   assign push      = (state_ff == S_EVAL) && do_split;

   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      level_in  = level_ff;
      count_in  = count_ff;
      evt.valid = 1'b0;
      evt.done  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (seg_valid) begin
               ax_in    = seg_ax;
               ay_in    = seg_ay;
               bx_in    = seg_bx;
               by_in    = seg_by;
               level_in = '0;
               count_in = '0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (is_inside) begin
               evt.valid = 1'b1;
               if (evt_ready) begin
                  count_in = count_next;
                  if (count_next == RES_LIMIT || level_ff == '0) begin
                     state_in = S_DONE;
                  end else begin
                     level_in = level_ff - LVL_BITS'(1);
                     state_in = S_READ;
                  end
               end
            end else if (do_split) begin
               bx_in    = mid_x;
               by_in    = mid_y;
               level_in = level_ff + LVL_BITS'(1);
            end else if (level_ff == '0) begin
               state_in = S_DONE;
            end else begin
               level_in = level_ff - LVL_BITS'(1);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            {ax_in, ay_in, bx_in, by_in} = rd_data_ff;
            state_in = S_EVAL;
         end
         S_DONE: begin
            evt.valid = 1'b1;
            evt.done  = 1'b1;
            if (evt_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         level_ff <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         count_ff <= count_in;
      end
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[level_ff[ADDR_BITS-1:0]] <= {mid_x, mid_y, bx_ff, by_ff};
      end
      if (state_ff == S_READ) begin
         rd_data_ff <= stack_mem[level_ff[ADDR_BITS-1:0]];
      end
   end

endmodule

// File: rtl/mlc_emit.sv
module mlc_emit
   import mlc_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mlc_evt_type                  evt,
   output logic                         evt_ready,
   input  logic signed [COORD_BITS-1:0] piece_x1,
   input  logic signed [COORD_BITS-1:0] piece_y1,
   input  logic signed [COORD_BITS-1:0] piece_x2,
   input  logic signed [COORD_BITS-1:0] piece_y2,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_piece_x1,
   output logic signed [COORD_BITS-1:0] rsp_piece_y1,
   output logic signed [COORD_BITS-1:0] rsp_piece_x2,
   output logic signed [COORD_BITS-1:0] rsp_piece_y2,
   output logic                         rsp_visible,
   output logic                         rsp_last
);

   localparam int SEG_BITS = 4 * COORD_BITS;

   // one visible piece is held back until it is known whether it is the last
   logic                held_valid_ff, held_valid_in;
   logic [SEG_BITS-1:0] held_ff, held_in;
   logic                out_valid_ff, out_valid_in;
   logic [SEG_BITS-1:0] out_seg_ff, out_seg_in;
   logic                out_vis_ff, out_vis_in;
   logic                out_last_ff, out_last_in;
   logic                take;

   assign evt_ready = !out_valid_ff || rsp_ready;
   assign take      = evt.valid && evt_ready;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_seg_in    = out_seg_ff;
      out_vis_in    = out_vis_ff;
      out_last_in   = out_last_ff;
      if (take) begin
         if (evt.done) begin
            out_valid_in  = 1'b1;
            out_vis_in    = held_valid_ff;
            out_last_in   = 1'b1;
            out_seg_in    = held_valid_ff ? held_ff : '0;
            held_valid_in = 1'b0;
         end else begin
            if (held_valid_ff) begin
               out_valid_in = 1'b1;
               out_vis_in   = 1'b1;
               out_last_in  = 1'b0;
               out_seg_in   = held_ff;
            end
            held_valid_in = 1'b1;
            held_in       = {piece_x1, piece_y1, piece_x2, piece_y2};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      held_ff     <= held_in;
      out_seg_ff  <= out_seg_in;
      out_vis_ff  <= out_vis_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_visible = out_vis_ff;
   assign rsp_last    = out_last_ff;
   assign {rsp_piece_x1, rsp_piece_y1, rsp_piece_x2, rsp_piece_y2} = out_seg_ff;

endmodule

// File: rtl/midpoint_line_clipper_unit.sv
// Midpoint subdivision line clipper.
// req_ channel: one segment per transaction (start and end point, signed).
// rsp_ channel: the visible pieces of that segment in subdivision order, the
//   final one flagged by rsp_last; a segment with no visible part gives one
//   transaction with rsp_visible low, rsp_last high and zero coordinates.
// csr_ channel: window edges, csr_index 0..3 = x_min, y_min, x_max, y_max.
//   Always ready; write only while no segment is in flight.
// A two-entry input queue decouples the request side from the subdivision
// engine. The engine evaluates one piece per cycle unless the output stalls
// it; a split keeps the first half and pushes the second onto the pending
// stack, and each pop first reads the stack memory in S_READ and S_LOAD.
// A segment never gives more results than 64. The first result appears
// the cycle after the second visible piece is evaluated or the segment
// completes, since each piece is held one step to set rsp_last.
// Reset: window returns to 0,0..639,479, queue and engine empty.
// When rsp_ready is low the engine stalls at its next result; the input
// queue keeps accepting until it holds two segments.
module midpoint_line_clipper_unit
   import mlc_pkg::*;
#(
   parameter int COORD_BITS  = 12,
   parameter int STACK_DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [COORD_BITS-1:0]        csr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_piece_x1,
   output logic signed [COORD_BITS-1:0] rsp_piece_y1,
   output logic signed [COORD_BITS-1:0] rsp_piece_x2,
   output logic signed [COORD_BITS-1:0] rsp_piece_y2,
   output logic                         rsp_visible,
   output logic                         rsp_last
);

   logic signed [COORD_BITS-1:0] x_min_ff, y_min_ff, x_max_ff, y_max_ff;
   logic                         seg_valid, seg_ready;
   logic signed [COORD_BITS-1:0] seg_ax, seg_ay, seg_bx, seg_by;
   mlc_evt_type                  evt;
   logic                         evt_ready;
   logic signed [COORD_BITS-1:0] piece_x1, piece_y1, piece_x2, piece_y2;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= '0;
         y_min_ff <= '0;
         x_max_ff <= COORD_BITS'(639);
         y_max_ff <= COORD_BITS'(479);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_X_MIN: x_min_ff <= csr_data;
            REG_Y_MIN: y_min_ff <= csr_data;
            REG_X_MAX: x_max_ff <= csr_data;
            REG_Y_MAX: y_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mlc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .seg_valid   (seg_valid),
      .seg_ready   (seg_ready),
      .seg_ax      (seg_ax),
      .seg_ay      (seg_ay),
      .seg_bx      (seg_bx),
      .seg_by      (seg_by)
   );

   mlc_engine #(
      .COORD_BITS  (COORD_BITS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .window_x_min (x_min_ff),
      .window_y_min (y_min_ff),
      .window_x_max (x_max_ff),
      .window_y_max (y_max_ff),
      .seg_valid    (seg_valid),
      .seg_ready    (seg_ready),
      .seg_ax       (seg_ax),
      .seg_ay       (seg_ay),
      .seg_bx       (seg_bx),
      .seg_by       (seg_by),
      .evt          (evt),
      .evt_ready    (evt_ready),
      .piece_x1     (piece_x1),
      .piece_y1     (piece_y1),
      .piece_x2     (piece_x2),
      .piece_y2     (piece_y2)
   );

   mlc_emit #(
      .COORD_BITS (COORD_BITS)
   ) u_emit (
      .clock        (clock),
      .reset        (reset),
      .evt          (evt),
      .evt_ready    (evt_ready),
      .piece_x1     (piece_x1),
      .piece_y1     (piece_y1),
      .piece_x2     (piece_x2),
      .piece_y2     (piece_y2),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_piece_x1 (rsp_piece_x1),
      .rsp_piece_y1 (rsp_piece_y1),
      .rsp_piece_x2 (rsp_piece_x2),
      .rsp_piece_y2 (rsp_piece_y2),
      .rsp_visible  (rsp_visible),
      .rsp_last     (rsp_last)
   );

endmodule

// File: rtl/mlc_checker.sv
`include "midpoint_line_clipper_unit_assert.svh"

module mlc_checker
   import mlc_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [COORD_BITS-1:0] rsp_piece_x1,
   input logic signed [COORD_BITS-1:0] rsp_piece_y1,
   input logic signed [COORD_BITS-1:0] rsp_piece_x2,
   input logic signed [COORD_BITS-1:0] rsp_piece_y2,
   input logic                         rsp_visible,
   input logic                         rsp_last
);

   `MLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_piece_x1, rsp_piece_y1, rsp_piece_x2, rsp_piece_y2, rsp_visible, rsp_last}), "rsp transaction changed while stalled")
   `MLC_ASSERT_IMPL(a_none_is_last, clock, reset, rsp_valid && !rsp_visible, rsp_last, "no-visible result without last")
   `MLC_ASSERT_IMPL(a_none_zero, clock, reset, rsp_valid && !rsp_visible, rsp_piece_x1 == '0 && rsp_piece_y1 == '0 && rsp_piece_x2 == '0 && rsp_piece_y2 == '0, "no-visible result with nonzero coordinates")
   `MLC_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid right after reset")

endmodule

bind midpoint_line_clipper_unit mlc_checker #(
   .COORD_BITS (COORD_BITS)
) u_mlc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_piece_x1 (rsp_piece_x1),
   .rsp_piece_y1 (rsp_piece_y1),
   .rsp_piece_x2 (rsp_piece_x2),
   .rsp_piece_y2 (rsp_piece_y2),
   .rsp_visible  (rsp_visible),
   .rsp_last     (rsp_last)
);
